[rtl/core/ssp_pkg.sv]
// Shared types, character codes and status codes of the subscription string parser.
`default_nettype none

package ssp_pkg;

  // Default saturation limit for character positions.
  localparam int unsigned MAX_TEXT_LEN_DEF = 65535;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_DUP     = 2'd3;

  // Item kind codes.
  localparam logic [1:0] KIND_QUOTE   = 2'd0;
  localparam logic [1:0] KIND_TRADE   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  // Characters of the grammar.
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // One input beat: at most one character of the text, flagged by has_char.
  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       last;
  } in_beat_t;

  // One result beat.
  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] error_pos;
    logic [15:0] end_pos;
    logic [1:0]  item_count;
    logic [1:0]  kind_a;
    logic [1:0]  kind_b;
    logic [1:0]  kind_c;
    logic [63:0] qty_a;
    logic [63:0] qty_b;
    logic [63:0] qty_c;
  } out_beat_t;

  // Characters of the leading "SUB:" text.
  function automatic logic [7:0] lead_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0:    c = 8'h53;
      2'd1:    c = 8'h55;
      2'd2:    c = 8'h42;
      default: c = 8'h3A;
    endcase
    return c;
  endfunction

  // Check made when a quantity closes: ok, unknown pattern or duplicate.
  function automatic logic [1:0] close_check(input logic        dseen,
                                             input logic        ovf,
                                             input logic [63:0] acc,
                                             input logic [2:0]  seen,
                                             input logic [1:0]  kind,
                                             input logic [1:0]  cnt);
    logic [1:0] r;
    if (!dseen || ovf || (acc == 64'd0)) begin
      r = ST_UNKNOWN;
    end else if (seen[kind] || (cnt == 2'd3)) begin
      r = ST_DUP;
    end else begin
      r = ST_OK;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/subscription_string_parser.sv]
// Top level of the subscription string parser: per-character parse state and result stage.
`default_nettype none

// Checks a text, one character per beat, against "SUB:" item { ';' item }, where an
// item is a kind letter Q, T or S followed by a nonzero decimal quantity that fits in
// 64 bits. One input beat is taken each clock cycle that in_stall is low; the parse state
// (prefix match, times-ten accumulate, close checks) updates in that same cycle, so the
// sustained rate is one character per cycle while in_stall stays low. The beat flagged
// last (with or without a character) produces one result beat, which appears on out in
// the cycle after that beat is taken when the output register is free; behind a stalled
// result it waits in a one-entry skid register and moves to out once the stalled result
// is taken, and while it waits in_stall holds up the following text. in_stall rises
// only while both hold a result. Positions count up to MAX_TEXT_LEN and are clamped to
// 16 bits on output. After a result the parser is back in its reset state.
module subscription_string_parser #(
  parameter int unsigned MAX_TEXT_LEN = ssp_pkg::MAX_TEXT_LEN_DEF
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic in_valid,
  output                     logic in_stall,
  input  wire ssp_pkg::in_beat_t  in_beat,
  output                     logic out_valid,
  input  wire                logic out_stall,
  output ssp_pkg::out_beat_t      out_beat
);
  import ssp_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_TEXT_LEN + 1);
  localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_TEXT_LEN);

  // Parse phases.
  localparam logic [1:0] PH_PREFIX = 2'd0;
  localparam logic [1:0] PH_KIND   = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;
  localparam logic [1:0] PH_DONE   = 2'd3;

  // Parse state.
  logic [1:0]       phase;
  logic [1:0]       prefix_index;
  logic [POS_W-1:0] position;
  logic [POS_W-1:0] item_start;
  logic [63:0]      accumulator;
  logic             overflow_flag;
  logic             digit_seen;
  logic [1:0]       current_kind;
  logic [2:0]       seen_kinds;
  logic [1:0]       count;
  logic [1:0]       kinds      [3];
  logic [63:0]      quantities [3];
  logic [1:0]       final_status;
  logic [POS_W-1:0] final_pos;

  logic [1:0]       phase_next;
  logic [1:0]       prefix_index_next;
  logic [POS_W-1:0] position_next;
  logic [POS_W-1:0] item_start_next;
  logic [63:0]      accumulator_next;
  logic             overflow_flag_next;
  logic             digit_seen_next;
  logic [1:0]       current_kind_next;
  logic [2:0]       seen_kinds_next;
  logic [1:0]       count_next;
  logic [1:0]       kinds_next      [3];
  logic [63:0]      quantities_next [3];
  logic [1:0]       final_status_next;
  logic [POS_W-1:0] final_pos_next;

  // Result stage.
  logic      skid_valid;
  out_beat_t skid_beat;
  out_beat_t result;

  logic accept;
  logic result_new;

  assign in_stall   = skid_valid;
  assign accept     = in_valid && !in_stall;
  assign result_new = accept && in_beat.last;

  // ---------------------------------------------------------------------------
  // Parse step: character first, then the end-of-text check on a last beat.
  // ---------------------------------------------------------------------------
  always_comb begin
    logic [1:0]       ph;
    logic [1:0]       pidx;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] istart;
    logic [63:0]      acc;
    logic             ovf;
    logic             dseen;
    logic [1:0]       ckind;
    logic [2:0]       seen;
    logic [1:0]       cnt;
    logic [1:0]       kd [3];
    logic [63:0]      qt [3];
    logic [1:0]       fst;
    logic [POS_W-1:0] fpos;
    logic [1:0]       chk;
    logic [67:0]      prod;
    logic [31:0]      fp_wide;
    logic [15:0]      fp16;
    logic             ok;

    ph     = phase;
    pidx   = prefix_index;
    pos    = position;
    istart = item_start;
    acc    = accumulator;
    ovf    = overflow_flag;
    dseen  = digit_seen;
    ckind  = current_kind;
    seen   = seen_kinds;
    cnt    = count;
    kd     = kinds;
    qt     = quantities;
    fst    = final_status;
    fpos   = final_pos;
    chk    = ST_OK;
    prod   = '0;

    if (in_beat.has_char) begin
      unique case (ph)
        PH_PREFIX: begin
          if (in_beat.ch == lead_char(pidx)) begin
            if (pidx == 2'd3) begin
              ph = PH_KIND;
            end else begin
              pidx = pidx + 2'd1;
            end
          end else begin
            ph   = PH_DONE;
            fst  = ST_UNKNOWN;
            fpos = '0;
          end
        end
        PH_KIND: begin
          istart = pos;
          if ((in_beat.ch == CH_Q) || (in_beat.ch == CH_T) || (in_beat.ch == CH_S)) begin
            ckind = (in_beat.ch == CH_Q) ? KIND_QUOTE :
                    (in_beat.ch == CH_T) ? KIND_TRADE : KIND_SUMMARY;
            acc   = '0;
            ovf   = 1'b0;
            dseen = 1'b0;
            ph    = PH_DIGITS;
          end else begin
            ph   = PH_DONE;
            fst  = ST_UNKNOWN;
            fpos = pos;
          end
        end
        PH_DIGITS: begin
          if ((in_beat.ch >= CH_ZERO) && (in_beat.ch <= CH_NINE)) begin
            dseen = 1'b1;
            if (!ovf) begin
              // acc*10 + d in 68 bits; any carry into the top nibble is overflow
              prod = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0}
                   + {64'd0, in_beat.ch[3:0]};
              if (prod[67:64] != 4'd0) begin
                ovf = 1'b1;
              end else begin
                acc = prod[63:0];
              end
            end
          end else begin
            chk = close_check(dseen, ovf, acc, seen, ckind, cnt);
            if (chk == ST_OK) begin
              seen[ckind] = 1'b1;
              kd[cnt]     = ckind;
              qt[cnt]     = acc;
              cnt         = cnt + 2'd1;
              if (in_beat.ch == CH_SEMI) begin
                ph = PH_KIND;
              end else begin
                ph   = PH_DONE;
                fst  = ST_OK;
                fpos = pos;
              end
            end else begin
              ph   = PH_DONE;
              fst  = chk;
              fpos = istart;
            end
          end
        end
        default: begin
          // decided already: later characters only move the position
        end
      endcase
      if (pos < POS_MAX) begin
        pos = pos + POS_W'(1);
      end
    end

    if (in_beat.last) begin
      unique case (ph)
        PH_PREFIX: begin
          ph   = PH_DONE;
          fst  = (pos == '0) ? ST_RANGE : ST_UNKNOWN;
          fpos = '0;
        end
        PH_KIND: begin
          ph   = PH_DONE;
          fst  = ST_UNKNOWN;
          fpos = pos;
        end
        PH_DIGITS: begin
          chk = close_check(dseen, ovf, acc, seen, ckind, cnt);
          ph  = PH_DONE;
          if (chk == ST_OK) begin
            seen[ckind] = 1'b1;
            kd[cnt]     = ckind;
            qt[cnt]     = acc;
            cnt         = cnt + 2'd1;
            fst         = ST_OK;
            fpos        = pos;
          end else begin
            fst  = chk;
            fpos = istart;
          end
        end
        default: begin
        end
      endcase
    end

    // result fields, masked by status and count
    fp_wide = 32'(fpos);
    fp16    = (fp_wide > 32'h0000_FFFF) ? 16'hFFFF : fp_wide[15:0];
    ok      = (fst == ST_OK);
    result.status     = fst;
    result.error_pos  = ok ? 16'd0 : fp16;
    result.end_pos    = ok ? fp16 : 16'd0;
    result.item_count = ok ? cnt : 2'd0;
    result.kind_a     = (ok && (cnt > 2'd0)) ? kd[0] : 2'd0;
    result.kind_b     = (ok && (cnt > 2'd1)) ? kd[1] : 2'd0;
    result.kind_c     = (ok && (cnt > 2'd2)) ? kd[2] : 2'd0;
    result.qty_a      = (ok && (cnt > 2'd0)) ? qt[0] : 64'd0;
    result.qty_b      = (ok && (cnt > 2'd1)) ? qt[1] : 64'd0;
    result.qty_c      = (ok && (cnt > 2'd2)) ? qt[2] : 64'd0;

    // a last beat sends the parser back to its reset state
    if (in_beat.last) begin
      phase_next         = PH_PREFIX;
      prefix_index_next  = '0;
      position_next      = '0;
      item_start_next    = '0;
      accumulator_next   = '0;
      overflow_flag_next = 1'b0;
      digit_seen_next    = 1'b0;
      current_kind_next  = '0;
      seen_kinds_next    = '0;
      count_next         = '0;
      final_status_next  = ST_OK;
      final_pos_next     = '0;
    end else begin
      phase_next         = ph;
      prefix_index_next  = pidx;
      position_next      = pos;
      item_start_next    = istart;
      accumulator_next   = acc;
      overflow_flag_next = ovf;
      digit_seen_next    = dseen;
      current_kind_next  = ckind;
      seen_kinds_next    = seen;
      count_next         = cnt;
      final_status_next  = fst;
      final_pos_next     = fpos;
    end
    // stored items are masked by count, so they need no clearing
    kinds_next      = kd;
    quantities_next = qt;
  end

  // ---------------------------------------------------------------------------
  // Parse state registers.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_PREFIX;
      prefix_index  <= '0;
      position      <= '0;
      item_start    <= '0;
      accumulator   <= '0;
      overflow_flag <= 1'b0;
      digit_seen    <= 1'b0;
      current_kind  <= '0;
      seen_kinds    <= '0;
      count         <= '0;
      final_status  <= ST_OK;
      final_pos     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      prefix_index  <= prefix_index_next;
      position      <= position_next;
      item_start    <= item_start_next;
      accumulator   <= accumulator_next;
      overflow_flag <= overflow_flag_next;
      digit_seen    <= digit_seen_next;
      current_kind  <= current_kind_next;
      seen_kinds    <= seen_kinds_next;
      count         <= count_next;
      final_status  <= final_status_next;
      final_pos     <= final_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kinds      <= kinds_next;
      quantities <= quantities_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Result stage: output register plus one skid entry.
  // The skid entry fills only when a new result arrives while out is stalled;
  // it drains into out at the next free slot.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= result_new;
      end
    end else if (result_new) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || !out_stall) begin
      if (skid_valid) begin
        out_beat <= skid_beat;
      end else if (result_new) begin
        out_beat <= result;
      end
    end else if (result_new) begin
      skid_beat <= result;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry holds a result while out is empty");

  a_seen_matches_count: assert property (@(posedge clk) disable iff (rst)
    $countones(seen_kinds) == 32'(count))
    else $error("seen kinds disagree with item count");

  a_items_after_prefix: assert property (@(posedge clk) disable iff (rst)
    (count != 2'd0) |-> (phase != PH_PREFIX))
    else $error("items recorded while still matching the prefix");

  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    result_new |=> out_valid)
    else $error("last beat taken but no result presented");

  a_last_clears_state: assert property (@(posedge clk) disable iff (rst)
    result_new |=> (phase == PH_PREFIX) && (count == 2'd0) && (position == '0))
    else $error("parse state not cleared after a result");

endmodule

`default_nettype wire
